// ===== rtl/bsfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_pkg: shared types and constants of the byte-stuffed frame receiver
// Framing bytes, status codes, phase and controller encodings, and the
// command/status bundles that link the controller to the datapath.
// ----------------------------------------------------------------------------
package bsfr_pkg;

	// Framing bytes
	localparam logic [7:0] SOF_BYTE = 8'h01;
	localparam logic [7:0] EOF_BYTE = 8'h17;
	localparam logic [7:0] ESC_BYTE = 8'hFF;

	// Escape codes that follow the marker
	localparam logic [7:0] ESC_CODE_SOF = 8'h00;
	localparam logic [7:0] ESC_CODE_EOF = 8'h02;
	localparam logic [7:0] ESC_CODE_ESC = 8'h03;

	// Defaults
	localparam int          DEF_MAX_FRAME_BYTES = 50;
	localparam logic [15:0] DEF_TIMEOUT_TICKS   = 16'd2000;

	// Configuration port
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 1'd1;

	// Operation field values
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADESC   = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_TIMEOUT  = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Frame phase
	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_BODY = 3'b010,
		PH_ESC  = 3'b100
	} phase_t;

	// Controller states
	typedef enum logic [3:0] {
		CS_IDLE     = 4'b0001,
		CS_EXEC     = 4'b0010,
		CS_DRAIN_RD = 4'b0100,
		CS_DRAIN_WR = 4'b1000
	} ctrl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;  // latch the input beat
		logic exec;    // apply the latched item
		logic rd;      // issue a frame store read
		logic emit;    // load the read byte into the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_out;  // latched item produces an error beat
		logic drain;     // latched item closes a non-empty frame
		logic out_free;  // output register can take a beat this cycle
		logic last_rd;   // current read index is the final stored byte
	} sts_t;

	// Decode an escape code; valid low for a bad escape
	function automatic logic [8:0] decode_escape(input logic [7:0] code);
		logic [8:0] res;
		unique case (code)
			ESC_CODE_SOF: res = {1'b1, SOF_BYTE};
			ESC_CODE_EOF: res = {1'b1, EOF_BYTE};
			ESC_CODE_ESC: res = {1'b1, ESC_BYTE};
			default:      res = 9'd0;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bsfr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_if: valid/ready channels of the byte-stuffed frame receiver
// Input channel carries serial bytes and ticks; output channel carries
// decoded frame bytes and status beats.
// ----------------------------------------------------------------------------
interface bsfr_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface bsfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [2:0] status;

	modport source (output valid, output out_byte, output last, output status, input ready);
	modport sink   (input valid, input out_byte, input last, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/bsfr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 50,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bsfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_ctrl: sequencing controller of the frame receiver
// Accepts one input beat, applies it, and walks the frame store beat by
// beat when a frame closes.
// ----------------------------------------------------------------------------
module bsfr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire bsfr_pkg::sts_t sts,
	output bsfr_pkg::cmd_t      cmd
);
	import bsfr_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = CS_EXEC;
				end
			end
			CS_EXEC: begin
				// hold while an error beat has nowhere to go
				if (!(sts.need_out && !sts.out_free)) begin
					cmd.exec  = 1'b1;
					state_nxt = sts.drain ? CS_DRAIN_RD : CS_IDLE;
				end
			end
			CS_DRAIN_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = CS_DRAIN_WR;
			end
			CS_DRAIN_WR: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = sts.last_rd ? CS_IDLE : CS_DRAIN_RD;
				end
			end
			default: begin
				state_nxt = CS_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef SYNTH
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == CS_EXEC))
		else $error("accepted beat not followed by execute");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_DRAIN_WR && cmd.emit && sts.last_rd) |=> (state_q == CS_IDLE))
		else $error("drain did not finish after last byte");

	a_exec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_EXEC && sts.need_out && !sts.out_free) |=> (state_q == CS_EXEC))
		else $error("error beat dropped while output stalled");
`endif

endmodule
`default_nettype wire

// ===== rtl/bsfr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_dp: datapath of the frame receiver
// Holds configuration, the latched input beat, frame phase, byte count,
// tick counter, the frame store and the output register.
// ----------------------------------------------------------------------------
module bsfr_dp #(
	parameter int MAX_FRAME_BYTES = bsfr_pkg::DEF_MAX_FRAME_BYTES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bsfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [bsfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            in_operation,
	input  wire logic [7:0]                      in_rx_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [7:0]                      out_byte,
	output logic                                 out_last,
	output logic      [2:0]                      out_status,
	input  wire bsfr_pkg::cmd_t                  cmd,
	output bsfr_pkg::sts_t                       sts
);
	import bsfr_pkg::*;

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

	// Configuration
	logic        en_q;
	logic [15:0] timeout_q;

	// Frame state
	logic          op_q;
	logic [7:0]    byte_q;
	phase_t        phase_q;
	logic [CW-1:0] count_q;
	logic [15:0]   ticks_q;
	logic [AW-1:0] rd_idx_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	status_t    out_status_q;

	// Item evaluation
	logic        ev_start;
	logic        ev_tick;
	logic        ev_esc;
	logic        ev_store;
	logic        ev_drain;
	logic        ev_err;
	status_t     ev_code;
	logic [7:0]  store_val;
	logic [15:0] ticks_inc;
	logic        store_req;
	logic [8:0]  esc_dec;
	logic [7:0]  ram_rdata;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b1;
			timeout_q <= DEF_TIMEOUT_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RECEIVE_ENABLE: en_q      <= cfg_wdata[0];
				CFG_TIMEOUT_TICKS:  timeout_q <= cfg_wdata[15:0];
				default:            ;
			endcase
		end
	end

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_operation;
			byte_q <= in_rx_byte;
		end
	end

	// Evaluate the latched item against the frame state
	always_comb begin
		ev_start  = 1'b0;
		ev_tick   = 1'b0;
		ev_esc    = 1'b0;
		ev_store  = 1'b0;
		ev_drain  = 1'b0;
		ev_err    = 1'b0;
		ev_code   = ST_OK;
		store_req = 1'b0;
		store_val = byte_q;
		esc_dec   = decode_escape(byte_q);
		ticks_inc = (ticks_q != 16'hFFFF) ? (ticks_q + 16'd1) : ticks_q;
		priority if (phase_q == PH_HUNT) begin
			ev_start = (op_q == OP_BYTE) && en_q && (byte_q == SOF_BYTE);
		end else if (op_q == OP_TICK) begin
			if (ticks_inc >= timeout_q) begin
				ev_err  = 1'b1;
				ev_code = ST_TIMEOUT;
			end else begin
				ev_tick = 1'b1;
			end
		end else if (byte_q == ESC_BYTE) begin
			ev_esc = 1'b1;
		end else if (byte_q == EOF_BYTE) begin
			if (count_q == '0) begin
				ev_err  = 1'b1;
				ev_code = ST_EMPTY;
			end else begin
				ev_drain = 1'b1;
			end
		end else if (phase_q == PH_ESC) begin
			if (esc_dec[8]) begin
				store_req = 1'b1;
				store_val = esc_dec[7:0];
			end else begin
				ev_err  = 1'b1;
				ev_code = ST_BADESC;
			end
		end else begin
			store_req = 1'b1;
		end
		// full store refuses data bytes
		if (store_req) begin
			if (count_q >= CW'(MAX_FRAME_BYTES)) begin
				ev_err  = 1'b1;
				ev_code = ST_OVERFLOW;
			end else begin
				ev_store = 1'b1;
			end
		end
	end

	// Frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			count_q  <= '0;
			ticks_q  <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.exec) begin
				priority if (ev_err) begin
					phase_q <= PH_HUNT;
					count_q <= '0;
					ticks_q <= '0;
				end else if (ev_start) begin
					phase_q <= PH_BODY;
					count_q <= '0;
					ticks_q <= '0;
				end else if (ev_tick) begin
					ticks_q <= ticks_inc;
				end else if (ev_esc) begin
					phase_q <= PH_ESC;
				end else if (ev_drain) begin
					// count stays until the last byte leaves
					phase_q  <= PH_HUNT;
					ticks_q  <= '0;
					rd_idx_q <= '0;
				end else if (ev_store) begin
					phase_q <= PH_BODY;
					count_q <= count_q + CW'(1);
				end else begin
					phase_q <= phase_q;
				end
			end
			// advance the drain
			if (cmd.emit) begin
				if (sts.last_rd) begin
					count_q <= '0;
				end else begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
			end
		end
	end

	// Frame store
	bsfr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_FRAME_BYTES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (cmd.exec && ev_store),
		.waddr (count_q[AW-1:0]),
		.wdata (store_val),
		.re    (cmd.rd),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || (cmd.exec && ev_err)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q   <= ram_rdata;
			out_last_q   <= sts.last_rd;
			out_status_q <= ST_OK;
		end else if (cmd.exec && ev_err) begin
			out_byte_q   <= 8'h00;
			out_last_q   <= 1'b1;
			out_status_q <= ev_code;
		end
	end

	// Status to the controller
	always_comb begin
		sts.need_out = ev_err;
		sts.drain    = ev_drain;
		sts.out_free = !out_valid_q || out_ready;
		sts.last_rd  = (CW'(rd_idx_q) == (count_q - CW'(1)));
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAME_BYTES))
		else $error("byte count beyond frame store");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(cmd.emit || (cmd.exec && ev_err)))
		else $error("output beat overwritten while stalled");

	a_err_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && ev_err) |=> (phase_q == PH_HUNT && count_q == '0 && out_last_q))
		else $error("error did not return to hunting");
`endif

endmodule
`default_nettype wire

// ===== rtl/byte_stuffed_frame_receiver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_core: byte-stuffed serial frame receiver
// Deframes stuffed serial bytes into decoded frame bytes with status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready beats of {operation, rx_byte}; operation high marks
//            a time tick, low a received serial byte.
//   out_ch : valid/ready beats of {out_byte, last, status}; a closed frame
//            gives one beat per stored byte, the final one with last set; an
//            error gives one beat with out_byte zero, last set and its code.
//   cfg    : cfg_we/cfg_idx/cfg_wdata write receive_enable (0) and
//            timeout_ticks (1); write only while the block is idle.
// Sequencing: an input beat is accepted, then applied; the next one is taken
// after that and after any drain it began. An error beat loads the output
// register when its input beat is applied. A closed frame drains through the
// one read port of the frame store (read, then load the output register).
// A waiting output beat does not block the next input beat; the block stalls
// only when it must place a new beat while the previous one is still held.
// Reset: arst_n clears phase to hunting, counts to zero, receive_enable to
// one and timeout_ticks to 2000; the frame store needs no clearing.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_core #(
	parameter int MAX_FRAME_BYTES = bsfr_pkg::DEF_MAX_FRAME_BYTES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bsfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [bsfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bsfr_in_if.sink                              in_ch,
	bsfr_out_if.source                           out_ch
);
	import bsfr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencing
	bsfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage and decode
	bsfr_dp #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_operation (in_ch.operation),
		.in_rx_byte   (in_ch.rx_byte),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_byte     (out_ch.out_byte),
		.out_last     (out_ch.last),
		.out_status   (out_ch.status),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
`default_nettype wire

// ===== sim/byte_stuffed_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_core_tb: self-checking bench of the frame receiver
// Feeds directed and random stuffed frames, noise and ticks through the input
// channel under several register settings. Both channels idle at random. A
// frame scoreboard predicts every decoded byte and status beat and checks
// each output beat field by field.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_core_tb;
	import bsfr_pkg::*;

	localparam int FRAME_CAP     = DEF_MAX_FRAME_BYTES;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		status_t    status;
	} beat_t;

	typedef enum {END_EOF, END_ESC_EOF, END_BADESC} frame_end_t;

	// Frame scoreboard: own copy of the deframer state and the expected beats
	class frame_scoreboard;
		logic        rx_enable;
		logic [15:0] tick_limit;
		phase_t      ph;
		int          count;
		logic [7:0]  store [FRAME_CAP];
		logic [15:0] elapsed;
		beat_t       pending [$];
		int          errors;

		function void reset_state();
			rx_enable  = 1'b1;
			tick_limit = DEF_TIMEOUT_TICKS;
			ph         = PH_HUNT;
			count      = 0;
			elapsed    = '0;
			errors     = 0;
			pending.delete();
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
			if (idx == CFG_RECEIVE_ENABLE)
				rx_enable = data[0];
			else if (idx == CFG_TIMEOUT_TICKS)
				tick_limit = data;
		endfunction

		// Queue one error beat and fall back to hunting
		function void raise_error(input status_t code);
			pending.push_back(beat_t'{data: 8'h00, last: 1'b1, status: code});
			ph      = PH_HUNT;
			count   = 0;
			elapsed = '0;
		endfunction

		function void note_input(input logic op, input logic [7:0] b);
			logic [7:0] v;
			// Drop everything but an enabled start byte while hunting
			if (ph == PH_HUNT) begin
				if (op == OP_BYTE && rx_enable && b == SOF_BYTE) begin
					ph      = PH_BODY;
					count   = 0;
					elapsed = '0;
				end
				return;
			end
			// Count ticks, saturating, and time out at the limit
			if (op == OP_TICK) begin
				if (elapsed != 16'hFFFF)
					elapsed++;
				if (elapsed >= tick_limit)
					raise_error(ST_TIMEOUT);
				return;
			end
			if (b == ESC_BYTE) begin
				ph = PH_ESC;
				return;
			end
			// End byte: drain the stored bytes, or report an empty frame
			if (b == EOF_BYTE) begin
				if (count == 0) begin
					raise_error(ST_EMPTY);
					return;
				end
				for (int k = 0; k < count; k++)
					pending.push_back(beat_t'{data: store[k], last: (k == count - 1),
						status: ST_OK});
				ph      = PH_HUNT;
				count   = 0;
				elapsed = '0;
				return;
			end
			// Decode an escape; bad escape wins over a full buffer
			if (ph == PH_ESC) begin
				case (b)
					ESC_CODE_SOF: v = SOF_BYTE;
					ESC_CODE_EOF: v = EOF_BYTE;
					ESC_CODE_ESC: v = ESC_BYTE;
					default: begin
						raise_error(ST_BADESC);
						return;
					end
				endcase
			end else begin
				v = b;
			end
			if (count >= FRAME_CAP) begin
				raise_error(ST_OVERFLOW);
				return;
			end
			store[count] = v;
			count++;
			ph = PH_BODY;
		endfunction

		function void check_result(input logic [7:0] data, input logic last,
				input logic [2:0] status);
			beat_t exp_beat;
			if (pending.size() == 0) begin
				$error("unexpected beat: out_byte %0h last %0b status %0d", data, last, status);
				errors++;
				return;
			end
			exp_beat = pending.pop_front();
			if (data !== exp_beat.data) begin
				$error("out_byte: expected %0h, actual %0h", exp_beat.data, data);
				errors++;
			end
			if (last !== exp_beat.last) begin
				$error("last: expected %0b, actual %0b", exp_beat.last, last);
				errors++;
			end
			if (status !== exp_beat.status) begin
				$error("status: expected %0d, actual %0d", exp_beat.status, status);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bsfr_in_if  in_ch ();
	bsfr_out_if out_ch ();

	frame_scoreboard sb = new();

	int src_gap_max = 4;
	int rx_gap_max  = 4;
	int rx_hold     = 0;
	int tick_pct    = 10;
	int items_sent  = 0;

	byte_stuffed_frame_receiver_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: give up after a generous number of cycles
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("byte_stuffed_frame_receiver_core_tb NOT OK");
		$finish;
	end

	// Output side: hold off on request, stall at random, check every beat
	initial begin : beat_sink
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = $urandom_range(0, rx_gap_max);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			sb.check_result(out_ch.out_byte, out_ch.last, out_ch.status);
		end
	end

	// Offer one beat after a random gap and wait until it is taken
	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.operation <= op;
		in_ch.rx_byte   <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_input(op, b);
		items_sent++;
	endtask

	// Pause the sender until every expected beat is in, then let the block go quiet
	task automatic settle(input int extra);
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Write both registers; spare data bits carry junk that must be masked
	task automatic apply_settings(input logic enable, input logic [15:0] ticks);
		logic [15:0] en_word;
		en_word = {15'($urandom), enable};
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_RECEIVE_ENABLE;
		cfg_wdata <= en_word;
		@(posedge clk);
		cfg_idx   <= CFG_TIMEOUT_TICKS;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(CFG_RECEIVE_ENABLE, en_word);
		sb.write_reg(CFG_TIMEOUT_TICKS, ticks);
	endtask

	// Send a stuffed frame of len decoded bytes with ticks mixed in
	task automatic send_frame(input int len, input frame_end_t ending);
		logic [7:0] v;
		logic [7:0] bad;
		send_item(OP_BYTE, SOF_BYTE);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_item(OP_TICK, 8'($urandom));
			case ($urandom_range(0, 7))
				0:       v = SOF_BYTE;
				1:       v = EOF_BYTE;
				2:       v = ESC_BYTE;
				default: v = 8'($urandom);
			endcase
			if (v == EOF_BYTE || v == ESC_BYTE || (v == SOF_BYTE && $urandom_range(0, 1))) begin
				// a repeated marker keeps the escape open
				if ($urandom_range(0, 15) == 0)
					send_item(OP_BYTE, ESC_BYTE);
				send_item(OP_BYTE, ESC_BYTE);
				send_item(OP_BYTE, (v == SOF_BYTE) ? ESC_CODE_SOF :
					(v == EOF_BYTE) ? ESC_CODE_EOF : ESC_CODE_ESC);
			end else begin
				send_item(OP_BYTE, v);
			end
		end
		case (ending)
			END_ESC_EOF: begin
				send_item(OP_BYTE, ESC_BYTE);
				send_item(OP_BYTE, EOF_BYTE);
			end
			END_BADESC: begin
				do
					bad = 8'($urandom);
				while (bad inside {ESC_CODE_SOF, ESC_CODE_EOF, ESC_CODE_ESC, EOF_BYTE, ESC_BYTE});
				send_item(OP_BYTE, ESC_BYTE);
				send_item(OP_BYTE, bad);
			end
			default: send_item(OP_BYTE, EOF_BYTE);
		endcase
	endtask

	// Mostly well-formed frames, with noise and broken frames in between
	task automatic random_traffic(input int target);
		int stop_at;
		int len;
		int pick;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_item(1'($urandom), 8'($urandom));
			end else if (pick < 12) begin
				send_item(OP_BYTE, SOF_BYTE);
				repeat ($urandom_range(1, 4)) send_item(1'($urandom), 8'($urandom));
			end else begin
				len = ($urandom_range(0, 24) == 0) ? $urandom_range(46, 52) : $urandom_range(0, 8);
				pick = $urandom_range(0, 19);
				send_frame(len, (pick == 0) ? END_BADESC : (pick == 1) ? END_ESC_EOF : END_EOF);
			end
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_idx         <= CFG_RECEIVE_ENABLE;
		cfg_wdata       <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.operation <= OP_BYTE;
		in_ch.rx_byte   <= 8'h00;
		sb.reset_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tick while hunting, empty frame, plain and escaped bytes
		send_item(OP_TICK, 8'hFF);
		send_item(OP_BYTE, SOF_BYTE);
		send_item(OP_BYTE, EOF_BYTE);
		send_item(OP_BYTE, SOF_BYTE);
		send_item(OP_BYTE, SOF_BYTE);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFE);
		send_item(OP_BYTE, ESC_BYTE);
		send_item(OP_BYTE, ESC_CODE_SOF);
		send_item(OP_BYTE, ESC_BYTE);
		send_item(OP_BYTE, ESC_CODE_EOF);
		send_item(OP_BYTE, ESC_BYTE);
		send_item(OP_BYTE, ESC_BYTE);
		send_item(OP_BYTE, ESC_CODE_ESC);
		send_item(OP_BYTE, 8'h80);
		send_item(OP_BYTE, EOF_BYTE);
		// end byte with an open escape, then a bad escape
		send_item(OP_BYTE, SOF_BYTE);
		send_item(OP_BYTE, 8'h55);
		send_item(OP_BYTE, ESC_BYTE);
		send_item(OP_BYTE, EOF_BYTE);
		send_item(OP_BYTE, SOF_BYTE);
		send_item(OP_BYTE, ESC_BYTE);
		send_item(OP_BYTE, 8'h04);
		// shortest timeout fires on the first tick
		settle(SETTLE_CYCLES);
		apply_settings(1'b1, 16'd1);
		send_item(OP_BYTE, SOF_BYTE);
		send_item(OP_TICK, 8'h00);
		// receiving disabled: start byte ignored
		settle(SETTLE_CYCLES);
		apply_settings(1'b0, 16'd1);
		send_item(OP_BYTE, SOF_BYTE);
		send_item(OP_BYTE, 8'h42);
		// clearing the enable mid-frame leaves the frame running
		settle(SETTLE_CYCLES);
		apply_settings(1'b1, 16'hFFFF);
		send_item(OP_BYTE, SOF_BYTE);
		send_item(OP_BYTE, 8'h42);
		settle(SETTLE_CYCLES);
		apply_settings(1'b0, 16'hFFFF);
		send_item(OP_BYTE, 8'h43);
		send_item(OP_TICK, 8'hA5);
		send_item(OP_BYTE, EOF_BYTE);
		settle(SETTLE_CYCLES);

		// Random: default timeout, full buffer cases first
		apply_settings(1'b1, DEF_TIMEOUT_TICKS);
		send_frame(FRAME_CAP, END_ESC_EOF);
		send_frame(FRAME_CAP + 1, END_EOF);
		random_traffic(30);
		settle(SETTLE_CYCLES);

		// No idling, longest timeout; the sink holds off to back the block up
		src_gap_max = 0;
		rx_gap_max  = 0;
		tick_pct    = 5;
		apply_settings(1'b1, 16'hFFFF);
		rx_hold = 300;
		send_frame(40, END_EOF);
		random_traffic(20);
		settle(SETTLE_CYCLES);

		// Short timeouts with plenty of ticks
		src_gap_max = 4;
		rx_gap_max  = 2;
		tick_pct    = 35;
		apply_settings(1'b1, 16'($urandom_range(3, 10)));
		random_traffic(40);
		settle(SETTLE_CYCLES);

		// Receiving disabled: everything is dropped
		apply_settings(1'b0, 16'($urandom_range(1, 65535)));
		random_traffic(10);
		settle(SETTLE_CYCLES);

		src_gap_max = 2;
		rx_gap_max  = 4;
		tick_pct    = 10;
		apply_settings(1'b1, 16'($urandom_range(12, 40)));
		random_traffic(20);
		settle(40);

		if (sb.errors == 0)
			$display("byte_stuffed_frame_receiver_core_tb OK");
		else
			$display("byte_stuffed_frame_receiver_core_tb NOT OK");
		$finish;
	end

endmodule
